FILE: sv/midi_held_note_tracker_assert.svh
// Assertion macros for the held-note tracker.
// Used by the top level; expects clk and rst_n in scope at the point of use.
`ifndef MIDI_HELD_NOTE_TRACKER_ASSERT_SVH
`define MIDI_HELD_NOTE_TRACKER_ASSERT_SVH
`ifndef SYNTHESIS
`define MHNT_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("held note tracker: same-cycle check failed");
`define MHNT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("held note tracker: next-cycle check failed");
`else
`define MHNT_ASSERT_IMPLY(lbl, ante, cons)
`define MHNT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: sv/mhnt_pkg.sv
// Shared types and constants of the held-note tracker.
// No dependencies; imported by every other file of the block but the assertion header.
`timescale 1ns / 1ps
package mhnt_pkg;

  localparam int NUM_NOTES = 128;
  localparam int NOTE_W    = 7;
  localparam int VEL_W     = 7;
  localparam int IDX_W     = 4;
  localparam int CNT_OUT_W = 5;

  // MIDI status decode
  localparam logic [7:0] KIND_MASK = 8'hF0;
  localparam logic [7:0] KIND_OFF  = 8'h80;
  localparam logic [7:0] KIND_ON   = 8'h90;

  // request opcodes
  typedef enum logic [1:0] {
    OP_MIDI     = 2'd0,
    OP_ACK      = 2'd1,
    OP_RD_ENTRY = 2'd2,
    OP_RD_KEY   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_SWEEP,
    ST_PRESS,
    ST_FIN
  } state_t;

  // one entry of the per-note tables
  typedef struct packed {
    logic [VEL_W-1:0] vel;
    logic             dmp;
  } key_entry_t;

  // latched request
  typedef struct packed {
    logic [1:0]        op;
    logic [7:0]        status_byte;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  velocity;
    logic              sustain_held;
    logic [IDX_W-1:0]  index;
  } req_t;

  // result word
  typedef struct packed {
    logic [CNT_OUT_W-1:0] held_count;
    logic                 changed;
    logic [NOTE_W-1:0]    entry_note;
    logic                 entry_new;
    logic [VEL_W-1:0]     key_velocity;
    logic                 key_damped;
    logic                 dropped;
  } res_t;

  // commands from the sequencer to the held list
  typedef struct packed {
    logic              start;
    logic              clr_fresh;
    logic              append;
    logic [NOTE_W-1:0] key;
    logic [IDX_W-1:0]  rd_index;
  } list_cmd_t;

  // status from the held list
  typedef struct packed {
    logic              done;
    logic              full;
    logic [NOTE_W-1:0] entry_note;
    logic              entry_new;
  } list_sts_t;

endpackage

FILE: sv/mhnt_in_if.sv
// Request channel of the held-note tracker: valid/ready plus request fields.
// Depends on mhnt_pkg.
`timescale 1ns / 1ps
interface mhnt_in_if import mhnt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic [7:0]        status_byte;
  logic [NOTE_W-1:0] note;
  logic [VEL_W-1:0]  velocity;
  logic              sustain_held;
  logic [IDX_W-1:0]  index;

  modport source (
    output valid, op, status_byte, note, velocity, sustain_held, index,
    input  ready
  );
  modport sink (
    input  valid, op, status_byte, note, velocity, sustain_held, index,
    output ready
  );
endinterface

FILE: sv/mhnt_out_if.sv
// Result channel of the held-note tracker: valid/ready plus result fields.
// Depends on mhnt_pkg.
`timescale 1ns / 1ps
interface mhnt_out_if import mhnt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CNT_OUT_W-1:0] held_count;
  logic                 changed;
  logic [NOTE_W-1:0]    entry_note;
  logic                 entry_new;
  logic [VEL_W-1:0]     key_velocity;
  logic                 key_damped;
  logic                 dropped;

  modport source (
    output valid, held_count, changed, entry_note, entry_new, key_velocity,
           key_damped, dropped,
    input  ready
  );
  modport sink (
    input  valid, held_count, changed, entry_note, entry_new, key_velocity,
           key_damped, dropped,
    output ready
  );
endinterface

FILE: sv/mhnt_table.sv
// Per-note velocity and damper table: 128-entry memory, registered read.
// Per-entry valid bits make unwritten entries read as zero after reset.
`timescale 1ns / 1ps
module mhnt_table import mhnt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [NOTE_W-1:0] rd_addr,
  output key_entry_t        rd_data,
  input  logic              wr_en,
  input  logic [NOTE_W-1:0] wr_addr,
  input  key_entry_t        wr_data
);

  key_entry_t           mem_r [NUM_NOTES];
  key_entry_t           rd_q_r;
  logic [NUM_NOTES-1:0] vld_r;
  logic                 rd_vld_r;

  // storage array, no reset
  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_addr] <= wr_data;
    if (rd_en) rd_q_r <= mem_r[rd_addr];
  end

  // written marks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) vld_r[wr_addr] <= 1'b1;
      if (rd_en) rd_vld_r <= vld_r[rd_addr];
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

FILE: sv/mhnt_cell.sv
// One slot of the held-note list: note, new-press flag and removal token.
// Depends on mhnt_pkg; chained by mhnt_list.
`timescale 1ns / 1ps
module mhnt_cell import mhnt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              tok_in,
  input  logic              fnd_in,
  input  logic              occ,
  input  logic [NOTE_W-1:0] key,
  input  logic              load,
  input  logic              clr_fresh,
  input  logic [NOTE_W-1:0] nbr_note,
  input  logic              nbr_fresh,
  output logic              tok_out,
  output logic              fnd_out,
  output logic [NOTE_W-1:0] note,
  output logic              fresh
);

  logic              tok_r;
  logic              fnd_r;
  logic [NOTE_W-1:0] note_r;
  logic              fresh_r;
  logic              match;
  logic              shift;

  // token arrives one cell per cycle; found marks that the gap is behind us
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
      fnd_r <= 1'b0;
    end else begin
      tok_r <= tok_in;
      fnd_r <= fnd_in;
    end
  end

  assign match = occ && (note_r == key);
  assign shift = tok_r && (fnd_r || match);

  // slot contents: append, close gap from the right neighbor, or clear flag
  always_ff @(posedge clk) begin
    if (load) begin
      note_r  <= key;
      fresh_r <= 1'b1;
    end else if (shift) begin
      note_r  <= nbr_note;
      fresh_r <= nbr_fresh;
    end else if (clr_fresh) begin
      fresh_r <= 1'b0;
    end
  end

  assign tok_out = tok_r;
  assign fnd_out = shift;
  assign note    = note_r;
  assign fresh   = fresh_r;

endmodule

FILE: sv/mhnt_list.sv
// Held-note list as a chain of mhnt_cell slots plus the entry count.
// Removal passes a token down the chain; depends on mhnt_pkg, mhnt_cell.
`timescale 1ns / 1ps
module mhnt_list import mhnt_pkg::*; #(
  parameter int MAX_HELD = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  list_cmd_t                       cmd,
  output logic [$clog2(MAX_HELD+1)-1:0]   held_count,
  output list_sts_t                       sts
);

  localparam int CW   = $clog2(MAX_HELD + 1);
  localparam int RDN  = (MAX_HELD < (1 << IDX_W)) ? MAX_HELD : (1 << IDX_W);
  localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;

  logic [CW-1:0]       cnt_r;
  logic [MAX_HELD-1:0] tok_in;
  logic [MAX_HELD-1:0] fnd_in;
  logic [MAX_HELD-1:0] tok_out;
  logic [MAX_HELD-1:0] fnd_out;
  logic [NOTE_W-1:0]   cell_note [MAX_HELD];
  logic [MAX_HELD-1:0] cell_fresh;
  logic [NOTE_W-1:0]   nbr_note  [MAX_HELD];
  logic [MAX_HELD-1:0] nbr_fresh;
  logic                full;
  logic                removed;
  logic [NOTE_W-1:0]   sel_note;
  logic                sel_fresh;
  logic                in_range;

  // cell chain
  for (genvar i = 0; i < MAX_HELD; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign tok_in[i] = cmd.start;
      assign fnd_in[i] = 1'b0;
    end else begin : g_link
      assign tok_in[i] = tok_out[i-1];
      assign fnd_in[i] = fnd_out[i-1];
    end
    if (i == MAX_HELD - 1) begin : g_tail
      assign nbr_note[i]  = '0;
      assign nbr_fresh[i] = 1'b0;
    end else begin : g_mid
      assign nbr_note[i]  = cell_note[i+1];
      assign nbr_fresh[i] = cell_fresh[i+1];
    end

    mhnt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .tok_in    (tok_in[i]),
      .fnd_in    (fnd_in[i]),
      .occ       (CW'(i) < cnt_r),
      .key       (cmd.key),
      .load      (cmd.append && !full && (cnt_r == CW'(i))),
      .clr_fresh (cmd.clr_fresh),
      .nbr_note  (nbr_note[i]),
      .nbr_fresh (nbr_fresh[i]),
      .tok_out   (tok_out[i]),
      .fnd_out   (fnd_out[i]),
      .note      (cell_note[i]),
      .fresh     (cell_fresh[i])
    );
  end

  assign full    = (cnt_r == CW'(MAX_HELD));
  assign removed = tok_out[MAX_HELD-1] && fnd_out[MAX_HELD-1];

  // entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.append && !full) begin
      cnt_r <= cnt_r + 1'b1;
    end else if (removed) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // entry read at the requested position
  always_comb begin
    sel_note  = '0;
    sel_fresh = 1'b0;
    for (int i = 0; i < RDN; i++) begin
      if (cmd.rd_index == IDX_W'(i)) begin
        sel_note  = cell_note[i];
        sel_fresh = cell_fresh[i];
      end
    end
  end

  assign in_range = CMPW'(cmd.rd_index) < CMPW'(cnt_r);

  assign held_count     = cnt_r;
  assign sts.done       = tok_out[MAX_HELD-1];
  assign sts.full       = full;
  assign sts.entry_note = in_range ? sel_note : '0;
  assign sts.entry_new  = in_range && sel_fresh;

endmodule

FILE: sv/midi_held_note_tracker.sv
// Held-note tracker for three-byte MIDI note messages.
//
// Requests arrive on in_req (valid/ready): op 0 carries a MIDI message, op 1
// acknowledges changes, op 2 reads a held-list entry at index, op 3 reads the
// velocity and damper mark of note. Every request returns one result on
// out_res (valid/ready) with the list count and change flag after the request.
// One request is worked at a time. Reads, acknowledge, ignored statuses and
// sustained note-off pass from the look state straight to the finish state;
// a note-on of an unheld note goes through the press state between them. A
// note-off runs a removal token down the slot chain in the sweep state, one
// slot per cycle. A note-on of a held note runs the token and then appends,
// the longest case. The next request is taken in the cycle after the result
// is loaded. If the receiver stalls, the result waits in the output register;
// the next request is still worked but holds its result until the register
// frees, and later requests wait.
// Synchronous reset empties the list, clears the change flag and marks every
// note-table entry as zero; the block takes requests in the first cycle after
// reset. Depends on mhnt_pkg, mhnt_in_if, mhnt_out_if, mhnt_table, mhnt_list.
`timescale 1ns / 1ps
`include "midi_held_note_tracker_assert.svh"
module midi_held_note_tracker import mhnt_pkg::*; #(
  parameter int MAX_HELD = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  mhnt_in_if.sink   in_req,
  mhnt_out_if.source out_res
);

  localparam int CW = $clog2(MAX_HELD + 1);

  state_t     state_r;
  state_t     state_nxt;
  req_t       req_r;
  logic       chg_r;
  logic       chg_nxt;
  logic       drop_r;
  logic       drop_nxt;
  logic       out_valid_r;
  res_t       out_res_r;
  res_t       res_nxt;
  logic       out_load;
  logic       accept;
  logic       is_on;
  logic       is_off;
  logic       retrig;

  key_entry_t tbl_rd;
  logic       tbl_wr_en;
  key_entry_t tbl_wr_data;
  list_cmd_t  cmd;
  list_sts_t  sts;
  logic [CW-1:0] cnt;

  assign in_req.ready = (state_r == ST_IDLE);
  assign accept       = in_req.valid && in_req.ready;

  // request decode
  assign is_on  = (req_r.op == OP_MIDI) && ((req_r.status_byte & KIND_MASK) == KIND_ON);
  assign is_off = (req_r.op == OP_MIDI) && ((req_r.status_byte & KIND_MASK) == KIND_OFF);
  assign retrig = is_on && (tbl_rd.vel != '0);

  // note tables
  mhnt_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (in_req.note),
    .rd_data (tbl_rd),
    .wr_en   (tbl_wr_en),
    .wr_addr (req_r.note),
    .wr_data (tbl_wr_data)
  );

  // held list
  mhnt_list #(.MAX_HELD(MAX_HELD)) u_list (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .held_count (cnt),
    .sts        (sts)
  );

  // request latch
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r.op           <= in_req.op;
      req_r.status_byte  <= in_req.status_byte;
      req_r.note         <= in_req.note;
      req_r.velocity     <= in_req.velocity;
      req_r.sustain_held <= in_req.sustain_held;
      req_r.index        <= in_req.index;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (accept) state_nxt = ST_LOOK;
      ST_LOOK: begin
        if ((is_off && !req_r.sustain_held) || retrig) state_nxt = ST_SWEEP;
        else if (is_on)                                state_nxt = ST_PRESS;
        else                                           state_nxt = ST_FIN;
      end
      ST_SWEEP: if (sts.done) state_nxt = is_on ? ST_PRESS : ST_FIN;
      ST_PRESS: state_nxt = ST_FIN;
      ST_FIN:   if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // state outputs: table writes, list commands, flags
  always_comb begin
    tbl_wr_en     = 1'b0;
    tbl_wr_data   = '0;
    cmd.start     = 1'b0;
    cmd.clr_fresh = 1'b0;
    cmd.append    = 1'b0;
    cmd.key       = req_r.note;
    cmd.rd_index  = req_r.index;
    chg_nxt       = chg_r;
    drop_nxt      = drop_r;
    out_load      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) drop_nxt = 1'b0;
      end
      ST_LOOK: begin
        if (is_off && req_r.sustain_held) begin
          tbl_wr_en   = 1'b1;
          tbl_wr_data = '{vel: tbl_rd.vel, dmp: 1'b1};
        end else if (is_off) begin
          tbl_wr_en   = 1'b1;
          tbl_wr_data = '{vel: '0, dmp: tbl_rd.dmp};
          chg_nxt     = 1'b1;
          cmd.start   = 1'b1;
        end else if (retrig) begin
          chg_nxt     = 1'b1;
          cmd.start   = 1'b1;
        end else if (req_r.op == OP_ACK) begin
          chg_nxt       = 1'b0;
          cmd.clr_fresh = 1'b1;
        end
      end
      ST_SWEEP: begin
      end
      ST_PRESS: begin
        tbl_wr_en   = 1'b1;
        tbl_wr_data = '{vel: req_r.velocity, dmp: 1'b0};
        chg_nxt     = 1'b1;
        if (sts.full) drop_nxt = 1'b1;
        else          cmd.append = 1'b1;
      end
      ST_FIN: begin
        out_load = !out_valid_r || out_res.ready;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      chg_r       <= 1'b0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      chg_r   <= chg_nxt;
      drop_r  <= drop_nxt;
      if (out_load)           out_valid_r <= 1'b1;
      else if (out_res.ready) out_valid_r <= 1'b0;
    end
  end

  // result assembly; fields of other ops read as zero
  always_comb begin
    res_nxt              = '0;
    res_nxt.held_count   = CNT_OUT_W'(cnt);
    res_nxt.changed      = chg_r;
    res_nxt.dropped      = drop_r;
    if (req_r.op == OP_RD_ENTRY) begin
      res_nxt.entry_note = sts.entry_note;
      res_nxt.entry_new  = sts.entry_new;
    end
    if (req_r.op == OP_RD_KEY) begin
      res_nxt.key_velocity = tbl_rd.vel;
      res_nxt.key_damped   = tbl_rd.dmp;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) out_res_r <= res_nxt;
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.held_count   = out_res_r.held_count;
  assign out_res.changed      = out_res_r.changed;
  assign out_res.entry_note   = out_res_r.entry_note;
  assign out_res.entry_new    = out_res_r.entry_new;
  assign out_res.key_velocity = out_res_r.key_velocity;
  assign out_res.key_damped   = out_res_r.key_damped;
  assign out_res.dropped      = out_res_r.dropped;

  // list never grows past its capacity
  `MHNT_ASSERT_IMPLY(a_cnt_bound, 1'b1, cnt <= CW'(MAX_HELD))
  // a removal sweep takes out at most one entry
  `MHNT_ASSERT_NEXT(a_sweep_one, state_r == ST_SWEEP, cnt == $past(cnt) || cnt == $past(cnt) - 1'b1)
  // an append is only issued with room left
  `MHNT_ASSERT_IMPLY(a_append_room, cmd.append, cnt < CW'(MAX_HELD))

endmodule

FILE: bench/midi_held_note_tracker_tb.sv
// Self-checking bench for midi_held_note_tracker: directed and random requests,
// scoreboarded against an in-bench model. Needs mhnt_pkg, mhnt_in_if, mhnt_out_if.
`timescale 1ns / 1ps
module midi_held_note_tracker_tb;
  import mhnt_pkg::*;

  localparam int HELD_MAX    = 16;
  localparam int HALF_PERIOD = 4;
  localparam int RAND_ITEMS  = 1730;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  mhnt_in_if  in_req ();
  mhnt_out_if out_res ();

  midi_held_note_tracker #(.MAX_HELD(HELD_MAX)) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_res (out_res)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // shadow copy of the tracker state
  logic [VEL_W-1:0]  note_vel  [NUM_NOTES];
  logic              note_damp [NUM_NOTES];
  logic [NOTE_W-1:0] slot_note [HELD_MAX];
  logic              slot_new  [HELD_MAX];
  int                slot_count;
  logic              dirty;

  req_t midi_req_q[$];
  res_t tracker_res_q[$];
  req_t cur_req;
  int   send_gap;
  int   recv_stall;
  logic send_calm;
  logic recv_calm;
  int   errors;

  // drop a note: zero velocity, remove first list occurrence
  function automatic void release_key(logic [NOTE_W-1:0] nn);
    note_vel[nn] = '0;
    dirty = 1'b1;
    for (int i = 0; i < slot_count; i++) begin
      if (slot_note[i] == nn) begin
        for (int j = i; j + 1 < slot_count; j++) begin
          slot_note[j] = slot_note[j+1];
          slot_new[j]  = slot_new[j+1];
        end
        slot_count--;
        return;
      end
    end
  endfunction

  // advance the shadow state by one request and return the expected result
  function automatic res_t track_request(req_t r);
    res_t res;
    logic [7:0] kind;
    res = '0;
    kind = r.status_byte & KIND_MASK;
    case (op_t'(r.op))
      OP_MIDI: begin
        if (kind == KIND_OFF) begin
          if (r.sustain_held) note_damp[r.note] = 1'b1;
          else release_key(r.note);
        end else if (kind == KIND_ON) begin
          if (note_vel[r.note] != '0) release_key(r.note);
          note_vel[r.note]  = r.velocity;
          note_damp[r.note] = 1'b0;
          dirty = 1'b1;
          if (slot_count >= HELD_MAX) begin
            res.dropped = 1'b1;
          end else begin
            slot_note[slot_count] = r.note;
            slot_new[slot_count]  = 1'b1;
            slot_count++;
          end
        end
      end
      OP_ACK: begin
        dirty = 1'b0;
        for (int i = 0; i < HELD_MAX; i++) slot_new[i] = 1'b0;
      end
      OP_RD_ENTRY: begin
        if (int'(r.index) < slot_count) begin
          res.entry_note = slot_note[r.index];
          res.entry_new  = slot_new[r.index];
        end
      end
      default: begin
        res.key_velocity = note_vel[r.note];
        res.key_damped   = note_damp[r.note];
      end
    endcase
    res.held_count = CNT_OUT_W'(slot_count);
    res.changed    = dirty;
    return res;
  endfunction

  function automatic req_t make_req(op_t op, logic [7:0] st, logic [NOTE_W-1:0] nn,
                                    logic [VEL_W-1:0] v, logic sus, logic [IDX_W-1:0] idx);
    req_t r;
    r.op           = op;
    r.status_byte  = st;
    r.note         = nn;
    r.velocity     = v;
    r.sustain_held = sus;
    r.index        = idx;
    return r;
  endfunction

  // idle length: mostly none or short, a few long
  function automatic int pick_gap(logic calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 87) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_diff(string field, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $display("%0t: mismatch %s expected %0d actual %0d", $time, field, exp_v, act_v);
      errors++;
    end
  endtask

  // request driver
  always @(posedge clk) begin
    req_t nxt;
    if (!rst_n) begin
      in_req.valid <= 1'b0;
      send_gap     <= 0;
      send_calm    <= 1'b0;
    end else begin
      if (in_req.valid && in_req.ready) begin
        tracker_res_q.push_back(track_request(cur_req));
        if ($urandom_range(0, 149) == 0) send_calm <= ~send_calm;
      end
      if (!in_req.valid || in_req.ready) begin
        if (send_gap > 0) begin
          in_req.valid <= 1'b0;
          send_gap     <= send_gap - 1;
        end else if (midi_req_q.size() != 0) begin
          nxt = midi_req_q.pop_front();
          cur_req             <= nxt;
          in_req.op           <= nxt.op;
          in_req.status_byte  <= nxt.status_byte;
          in_req.note         <= nxt.note;
          in_req.velocity     <= nxt.velocity;
          in_req.sustain_held <= nxt.sustain_held;
          in_req.index        <= nxt.index;
          in_req.valid        <= 1'b1;
          send_gap            <= pick_gap(send_calm);
        end else begin
          in_req.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver back-pressure
  always @(posedge clk) begin
    logic rdy_n;
    int   stall_n;
    res_t exp_r;
    if (!rst_n) begin
      out_res.ready <= 1'b0;
      recv_stall    <= 0;
      recv_calm     <= 1'b0;
    end else begin
      rdy_n   = 1'b1;
      stall_n = recv_stall;
      if (out_res.valid && out_res.ready) begin
        if (tracker_res_q.size() == 0) begin
          $display("%0t: unexpected result, held_count %0d", $time, out_res.held_count);
          errors++;
        end else begin
          exp_r = tracker_res_q.pop_front();
          report_diff("held_count", exp_r.held_count, out_res.held_count);
          report_diff("changed", exp_r.changed, out_res.changed);
          report_diff("entry_note", exp_r.entry_note, out_res.entry_note);
          report_diff("entry_new", exp_r.entry_new, out_res.entry_new);
          report_diff("key_velocity", exp_r.key_velocity, out_res.key_velocity);
          report_diff("key_damped", exp_r.key_damped, out_res.key_damped);
          report_diff("dropped", exp_r.dropped, out_res.dropped);
        end
        stall_n = pick_gap(recv_calm);
        if ($urandom_range(0, 149) == 0) recv_calm <= ~recv_calm;
      end else if (out_res.ready && !recv_calm && $urandom_range(0, 15) == 0) begin
        // stall while the block is still busy too
        stall_n = $urandom_range(1, 4);
      end
      if (stall_n > 0) begin
        rdy_n = 1'b0;
        stall_n--;
      end
      out_res.ready <= rdy_n;
      recv_stall    <= stall_n;
    end
  end

  // stimulus, reset and end of run
  initial begin
    int base;
    int r;
    logic [NOTE_W-1:0] nn;
    in_req.valid        = 1'b0;
    in_req.op           = '0;
    in_req.status_byte  = '0;
    in_req.note         = '0;
    in_req.velocity     = '0;
    in_req.sustain_held = 1'b0;
    in_req.index        = '0;
    out_res.ready       = 1'b0;
    errors     = 0;
    slot_count = 0;
    dirty      = 1'b0;
    for (int i = 0; i < NUM_NOTES; i++) begin
      note_vel[i]  = '0;
      note_damp[i] = 1'b0;
    end
    for (int i = 0; i < HELD_MAX; i++) begin
      slot_note[i] = '0;
      slot_new[i]  = 1'b0;
    end

    // directed: reads on empty state, extremes, re-press, sustain, ignored status
    midi_req_q.push_back(make_req(OP_RD_ENTRY, 8'hFF, 7'd127, 7'd127, 1'b1, 4'd15));
    midi_req_q.push_back(make_req(OP_RD_KEY, 8'h00, 7'd127, 7'd0, 1'b0, 4'd0));
    midi_req_q.push_back(make_req(OP_MIDI, KIND_ON, 7'd0, 7'd127, 1'b0, 4'd0));
    midi_req_q.push_back(make_req(OP_MIDI, 8'h9F, 7'd127, 7'd0, 1'b1, 4'd15));
    midi_req_q.push_back(make_req(OP_MIDI, 8'h93, 7'd0, 7'd64, 1'b0, 4'd0));
    midi_req_q.push_back(make_req(OP_MIDI, KIND_OFF, 7'd0, 7'd0, 1'b1, 4'd0));
    midi_req_q.push_back(make_req(OP_RD_KEY, 8'h00, 7'd0, 7'd0, 1'b0, 4'd0));
    midi_req_q.push_back(make_req(OP_MIDI, 8'h8F, 7'd5, 7'd127, 1'b0, 4'd0));
    midi_req_q.push_back(make_req(OP_MIDI, 8'hF0, 7'd9, 7'd9, 1'b0, 4'd0));
    midi_req_q.push_back(make_req(OP_MIDI, 8'hA0, 7'd0, 7'd9, 1'b0, 4'd0));
    midi_req_q.push_back(make_req(OP_RD_ENTRY, 8'h00, 7'd0, 7'd0, 1'b0, 4'd0));
    midi_req_q.push_back(make_req(OP_ACK, 8'hFF, 7'd127, 7'd127, 1'b1, 4'd15));
    midi_req_q.push_back(make_req(OP_RD_ENTRY, 8'h00, 7'd0, 7'd0, 1'b0, 4'd1));
    // fill the list, then one note-on past full
    for (int i = 0; i < HELD_MAX - 2; i++)
      midi_req_q.push_back(make_req(OP_MIDI, KIND_ON, NOTE_W'(10 + i), 7'd100, 1'b0, 4'd0));
    midi_req_q.push_back(make_req(OP_MIDI, KIND_ON, 7'd30, 7'd1, 1'b0, 4'd0));
    midi_req_q.push_back(make_req(OP_RD_ENTRY, 8'h00, 7'd0, 7'd0, 1'b0, 4'd15));
    midi_req_q.push_back(make_req(OP_MIDI, KIND_OFF, 7'd127, 7'd0, 1'b0, 4'd0));

    // random: note traffic over a narrow window so the list fills and notes collide
    base = 0;
    for (int k = 0; k < RAND_ITEMS; k++) begin
      if (k % 200 == 0) base = $urandom_range(0, NUM_NOTES - 20);
      nn = NOTE_W'(base + $urandom_range(0, 19));
      r  = $urandom_range(0, 99);
      if (r < 40) begin
        midi_req_q.push_back(make_req(OP_MIDI, {4'h9, 4'($urandom)}, nn,
                                      7'($urandom), 1'($urandom), 4'($urandom)));
      end else if (r < 65) begin
        midi_req_q.push_back(make_req(OP_MIDI, {4'h8, 4'($urandom)}, nn, 7'($urandom),
                                      ($urandom_range(0, 9) < 3), 4'($urandom)));
      end else if (r < 80) begin
        midi_req_q.push_back(make_req(OP_RD_ENTRY, 8'($urandom), 7'($urandom),
                                      7'($urandom), 1'($urandom), 4'($urandom)));
      end else if (r < 90) begin
        midi_req_q.push_back(make_req(OP_RD_KEY, 8'($urandom), nn,
                                      7'($urandom), 1'($urandom), 4'($urandom)));
      end else if (r < 95) begin
        midi_req_q.push_back(make_req(OP_ACK, 8'($urandom), 7'($urandom),
                                      7'($urandom), 1'($urandom), 4'($urandom)));
      end else begin
        // noise: any op, any status, any note
        midi_req_q.push_back(make_req(op_t'($urandom_range(0, 3)), 8'($urandom),
                                      7'($urandom), 7'($urandom), 1'($urandom),
                                      4'($urandom)));
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (midi_req_q.size() != 0 || in_req.valid) @(posedge clk);
    while (tracker_res_q.size() != 0) @(posedge clk);
    repeat (HELD_MAX + 10) @(posedge clk);

    if (errors == 0 && tracker_res_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #8_000_000;
    $display("%0t: timeout, %0d results outstanding", $time, tracker_res_q.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/mhnt_pkg.sv
sv/mhnt_in_if.sv
sv/mhnt_out_if.sv
sv/mhnt_table.sv
sv/mhnt_cell.sv
sv/mhnt_list.sv
sv/midi_held_note_tracker.sv
bench/midi_held_note_tracker_tb.sv
